>>> rtl/core/rmfc_pkg.sv
// types and constants shared by the range median filter calibrator
package rmfc_pkg;

   // reading status code that marks a phase failure
   localparam logic [3:0]  STATUS_PHASE_FAIL  = 4'd4;
   // readings collected by one calibration
   localparam logic [3:0]  CAL_SAMPLES        = 4'd10;
   // readings that prime the filter ring after calibration
   localparam logic [3:0]  PRIME_SAMPLES      = 4'd3;
   // max_distance after reset
   localparam logic [15:0] MAX_DISTANCE_RESET = 16'd800;
   // last slot of the three-entry ring
   localparam logic [1:0]  RING_LAST          = 2'd2;
   // slot index that is never reached, treated as slot zero
   localparam logic [1:0]  RING_BAD           = 2'd3;

   typedef enum logic {
      OP_READING   = 1'b0,
      OP_CALIBRATE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_COLLECT = 2'd1,
      PHASE_PRIME   = 2'd2
   } phase_type;

   // input transaction
   typedef struct packed {
      logic        kind;
      logic [15:0] range_mm;
      logic [3:0]  range_status;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [15:0] distance_mm;
      logic        distance_valid;
      logic        calibrating;
      logic [18:0] baseline_eighths;
      logic        baseline_valid;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type      op;
      logic        valid;
      logic [15:0] range_mm;
   } cmd_type;

   // head of the command queue as the back end sees it
   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } cmd_head_type;

endpackage

>>> rtl/core/range_median_filter_calibrator.sv
// top level of the range median filter calibrator
//
// Input channel: req_push / req_full; a transaction carries a reading
// (kind 0, range_mm, range_status) or a calibrate command (kind 1). It is
// taken at a clock edge with req_push high and req_full low.
// Result channel: rsp_empty / rsp_pop; every input transaction yields one
// result, presented while rsp_empty is low and taken when rsp_pop is high.
// Configuration: csr_write_en / csr_write_data write max_distance at once;
// write it only while no transaction is in flight.
// Path: a transaction is registered in the command queue and then in the
// result queue before its result shows on rsp_data and can be popped.
// Throughput: one transaction per cycle while the result queue is not full,
// set by the combinational compare network and running sums in the back end.
// Reset: both queues are emptied, max_distance returns to 800 mm, the
// ring is marked unfilled and no baseline is held.
// Stall: when the receiver stops popping, the result queue fills after
// QUEUE_DEPTH results, then the command queue fills and req_full rises.
module range_median_filter_calibrator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [15:0]       csr_write_data,
   input  logic              req_push,
   input  rmfc_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output rmfc_pkg::rsp_type rsp_data,
   output logic              rsp_empty
);
   import rmfc_pkg::*;

   cmd_head_type cmd_head;
   logic         cmd_pop;

   // front end: classification and command queue
   rmfc_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .cmd_pop        (cmd_pop),
      .cmd_head       (cmd_head)
   );

   // back end: filtering, calibration and result queue
   rmfc_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

endmodule

>>> rtl/core/rmfc_fifo.sv
// small first-word-fall-through queue built from registers
module rmfc_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status and transfer qualifiers
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/rmfc_front.sv
// front end: holds max_distance, classifies readings and queues commands
module rmfc_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [15:0]           csr_write_data,
   input  logic                  req_push,
   input  rmfc_pkg::req_type     req_data,
   output logic                  req_full,
   input  logic                  cmd_pop,
   output rmfc_pkg::cmd_head_type cmd_head
);
   import rmfc_pkg::*;

   logic [15:0] max_dist_ff, max_dist_in;
   cmd_type     cmd_in;
   cmd_type     cmd_out;
   logic        cmd_empty;

   // configuration register
   assign max_dist_in = csr_write_en ? csr_write_data : max_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DISTANCE_RESET;
      end else begin
         max_dist_ff <= max_dist_in;
      end
   end

   // classify the incoming transaction
   always_comb begin
      cmd_in.op       = req_data.kind ? OP_CALIBRATE : OP_READING;
      cmd_in.valid    = (req_data.range_status != STATUS_PHASE_FAIL)
                        && (req_data.range_mm != '0)
                        && (req_data.range_mm <= max_dist_ff);
      cmd_in.range_mm = req_data.range_mm;
   end

   // command queue towards the back end
   rmfc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   assign cmd_head.empty = cmd_empty;
   assign cmd_head.cmd   = cmd_out;

endmodule

>>> rtl/core/rmfc_back.sv
// back end: calibration sequencer, median ring and result queue
module rmfc_back #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rmfc_pkg::cmd_head_type cmd_head,
   output logic                   cmd_pop,
   input  logic                   rsp_pop,
   output rmfc_pkg::rsp_type      rsp_data,
   output logic                   rsp_empty
);
   import rmfc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  cal_count_ff, cal_count_in;
   logic [15:0] cal_min_ff, cal_min_in;
   logic [15:0] cal_max_ff, cal_max_in;
   logic [19:0] cal_sum_ff, cal_sum_in;
   logic [18:0] baseline_ff, baseline_in;
   logic        baseline_set_ff, baseline_set_in;
   logic [15:0] ring_ff [3];
   logic [1:0]  ring_idx_ff, ring_idx_in;
   logic        ring_ready_ff, ring_ready_in;

   cmd_type     cmd;
   rsp_type     rsp;
   logic        rsp_full;
   logic        go;
   logic        is_cal;
   logic        rd;
   logic        in_collect;
   logic        in_prime;
   logic        in_idle;
   logic        first;
   logic [15:0] base_min, base_max, coll_min, coll_max;
   logic [19:0] coll_sum;
   logic [19:0] coll_base;
   logic [3:0]  next_count;
   logic        collect_done;
   logic        prime_done;
   logic        do_push;
   logic [1:0]  slot;
   logic        wrap;
   logic        ready_next;
   logic [15:0] r0, r1, r2;
   logic [15:0] lo01, hi01, mid_hi, median;

   // transfer control
   assign cmd        = cmd_head.cmd;
   assign go         = !cmd_head.empty && !rsp_full;
   assign cmd_pop    = go;
   assign is_cal     = (cmd.op == OP_CALIBRATE);
   assign rd         = (cmd.op == OP_READING) && cmd.valid;
   assign in_collect = (phase_ff == PHASE_COLLECT);
   assign in_prime   = (phase_ff == PHASE_PRIME);
   assign in_idle    = !in_collect && !in_prime;

   // collection running min, max and sum
   assign first        = (cal_count_ff == '0);
   assign base_min     = first ? cmd.range_mm : cal_min_ff;
   assign base_max     = first ? cmd.range_mm : cal_max_ff;
   assign coll_min     = (cmd.range_mm < base_min) ? cmd.range_mm : base_min;
   assign coll_max     = (cmd.range_mm > base_max) ? cmd.range_mm : base_max;
   assign coll_sum     = (first ? 20'd0 : cal_sum_ff) + {4'd0, cmd.range_mm};
   assign coll_base    = coll_sum - {4'd0, coll_min} - {4'd0, coll_max};
   assign next_count   = cal_count_ff + 4'd1;
   assign collect_done = (next_count >= CAL_SAMPLES);
   assign prime_done   = (next_count >= PRIME_SAMPLES);

   // ring write slot and wrap
   assign do_push    = rd && !in_collect;
   assign slot       = (ring_idx_ff == RING_BAD) ? 2'd0 : ring_idx_ff;
   assign wrap       = (slot == RING_LAST);
   assign ready_next = ring_ready_ff || (do_push && wrap)
                       || (in_prime && rd && prime_done);

   // three-input median over the ring after this write
   assign r0     = (do_push && slot == 2'd0) ? cmd.range_mm : ring_ff[0];
   assign r1     = (do_push && slot == 2'd1) ? cmd.range_mm : ring_ff[1];
   assign r2     = (do_push && slot == RING_LAST) ? cmd.range_mm : ring_ff[2];
   assign lo01   = (r0 < r1) ? r0 : r1;
   assign hi01   = (r0 < r1) ? r1 : r0;
   assign mid_hi = (hi01 < r2) ? hi01 : r2;
   assign median = (lo01 > mid_hi) ? lo01 : mid_hi;

   // next calibration phase
   always_comb begin
      phase_in = phase_ff;
      if (go) begin
         priority if (is_cal) begin
            phase_in = PHASE_COLLECT;
         end else if (rd) begin
            unique case (phase_ff)
               PHASE_COLLECT: if (collect_done) phase_in = PHASE_PRIME;
               PHASE_PRIME:   if (prime_done) phase_in = PHASE_IDLE;
               default:       phase_in = PHASE_IDLE;
            endcase
         end
      end
   end

   // calibration datapath and ring updates
   always_comb begin
      cal_count_in    = cal_count_ff;
      cal_min_in      = cal_min_ff;
      cal_max_in      = cal_max_ff;
      cal_sum_in      = cal_sum_ff;
      baseline_in     = baseline_ff;
      baseline_set_in = baseline_set_ff;
      ring_idx_in     = ring_idx_ff;
      ring_ready_in   = ring_ready_ff;
      if (go) begin
         priority if (is_cal) begin
            cal_count_in = '0;
            cal_min_in   = '0;
            cal_max_in   = '0;
            cal_sum_in   = '0;
         end else if (rd && in_collect) begin
            cal_min_in   = coll_min;
            cal_max_in   = coll_max;
            cal_sum_in   = coll_sum;
            cal_count_in = collect_done ? 4'd0 : next_count;
            if (collect_done) begin
               baseline_in     = coll_base[18:0];
               baseline_set_in = 1'b1;
            end
         end else if (rd && in_prime) begin
            cal_count_in = prime_done ? 4'd0 : next_count;
         end
         if (do_push) begin
            ring_idx_in = wrap ? 2'd0 : slot + 2'd1;
         end
         ring_ready_in = ready_next;
      end
   end

   // result of this transaction
   always_comb begin
      rsp.distance_valid   = in_idle && rd;
      rsp.distance_mm      = (in_idle && rd) ? (ready_next ? median : cmd.range_mm) : '0;
      rsp.calibrating      = is_cal || !in_idle;
      rsp.baseline_eighths = baseline_in;
      rsp.baseline_valid   = baseline_set_in;
   end

   // control and calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         cal_count_ff    <= '0;
         cal_min_ff      <= '0;
         cal_max_ff      <= '0;
         cal_sum_ff      <= '0;
         baseline_ff     <= '0;
         baseline_set_ff <= 1'b0;
         ring_idx_ff     <= '0;
         ring_ready_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         cal_count_ff    <= cal_count_in;
         cal_min_ff      <= cal_min_in;
         cal_max_ff      <= cal_max_in;
         cal_sum_ff      <= cal_sum_in;
         baseline_ff     <= baseline_in;
         baseline_set_ff <= baseline_set_in;
         ring_idx_ff     <= ring_idx_in;
         ring_ready_ff   <= ring_ready_in;
      end
   end

   // ring entries, read only once the ring has filled
   always_ff @(posedge clock) begin
      if (go && do_push) begin
         ring_ff[slot] <= cmd.range_mm;
      end
   end

   // result queue towards the receiver
   rmfc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (go),
      .push_data (rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

>>> rtl/core/rmfc_checker.sv
// port-level checks for the range median filter calibrator, with bind
module rmfc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_pop,
   input rmfc_pkg::rsp_type rsp_data,
   input logic              rsp_empty
);
   import rmfc_pkg::*;

   // no result waits and the input is not full right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result queue not empty after reset");

   // a calibrating result never carries a distance
   a_cal_no_distance: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.calibrating |-> !rsp_data.distance_valid)
      else $error("distance reported during calibration");

   // an invalid distance reads as zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.distance_valid |-> rsp_data.distance_mm == '0)
      else $error("nonzero distance without distance_valid");

   // no baseline value before a calibration completes
   a_baseline_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.baseline_valid |-> rsp_data.baseline_eighths == '0)
      else $error("baseline shown before calibration");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind range_median_filter_calibrator rmfc_checker u_checker (.*);

>>> tb/sv/tb.sv
// testbench for the range median filter calibrator: queue driver, result monitor and predictor
`timescale 1ns / 1ps

module tb;
   import rmfc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 3;

   typedef enum logic [1:0] {
      ACT_SEND,
      ACT_WRITE,
      ACT_DRAIN
   } act_type;

   typedef struct {
      act_type     act;
      req_type     req;
      logic [15:0] value;
      int unsigned gap;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_push = 1'b0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        rsp_empty;

   range_median_filter_calibrator DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_data       (req_data),
      .req_full       (req_full),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .rsp_empty      (rsp_empty)
   );

   // clock generation
   always #5 clock = ~clock;

   step_type    pending_q[$];
   rsp_type     awaited_outputs[$];

   // predictor state
   logic [15:0] lim_mm = MAX_DISTANCE_RESET;
   logic [15:0] ring[3] = '{16'd0, 16'd0, 16'd0};
   logic [1:0]  ring_pos = 2'd0;
   logic        ring_full = 1'b0;
   phase_type   phase = PHASE_IDLE;
   logic [3:0]  cal_cnt = 4'd0;
   logic [15:0] cal_lo = 16'd0;
   logic [15:0] cal_hi = 16'd0;
   logic [19:0] cal_acc = 20'd0;
   logic [18:0] base_store = 19'd0;
   logic        base_set = 1'b0;

   // run statistics
   int unsigned items_built = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned fault_count = 0;
   int unsigned cal_done = 0;
   int unsigned medians_out = 0;
   int unsigned csr_writes = 0;
   int unsigned cycles = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned quiet = 0;

   function automatic void note_fault(string what);
      fault_count++;
      if (fault_count <= 10)
         $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   // write one reading into the ring, marking it filled on wrap
   function automatic void store_in_ring(logic [15:0] v);
      logic [1:0] slot;
      slot = (ring_pos == RING_BAD) ? 2'd0 : ring_pos;
      ring[slot] = v;
      if (slot == RING_LAST) begin
         ring_pos = 2'd0;
         ring_full = 1'b1;
      end else begin
         ring_pos = slot + 2'd1;
      end
   endfunction

   // filter and calibration behaviour for one transaction
   function automatic rsp_type median_calibrate_step(req_type r);
      rsp_type     o;
      logic        ok;
      logic [15:0] lo, hi, c;
      o = '0;
      ok = (r.range_status != STATUS_PHASE_FAIL) && (r.range_mm != 16'd0)
           && (r.range_mm <= lim_mm);
      if (r.kind == OP_CALIBRATE) begin
         phase = PHASE_COLLECT;
         cal_cnt = 4'd0;
         cal_lo = 16'd0;
         cal_hi = 16'd0;
         cal_acc = 20'd0;
         o.calibrating = 1'b1;
      end else if (phase == PHASE_COLLECT) begin
         o.calibrating = 1'b1;
         if (ok) begin
            if (cal_cnt == 4'd0) begin
               cal_lo = r.range_mm;
               cal_hi = r.range_mm;
               cal_acc = 20'd0;
            end
            if (r.range_mm < cal_lo) cal_lo = r.range_mm;
            if (r.range_mm > cal_hi) cal_hi = r.range_mm;
            cal_acc = cal_acc + 20'(r.range_mm);
            cal_cnt = cal_cnt + 4'd1;
            if (cal_cnt >= CAL_SAMPLES) begin
               base_store = 19'(cal_acc - 20'(cal_lo) - 20'(cal_hi));
               base_set = 1'b1;
               phase = PHASE_PRIME;
               cal_cnt = 4'd0;
               cal_done++;
            end
         end
      end else if (phase == PHASE_PRIME) begin
         o.calibrating = 1'b1;
         if (ok) begin
            store_in_ring(r.range_mm);
            cal_cnt = cal_cnt + 4'd1;
            if (cal_cnt >= PRIME_SAMPLES) begin
               ring_full = 1'b1;
               phase = PHASE_IDLE;
               cal_cnt = 4'd0;
            end
         end
      end else if (ok) begin
         store_in_ring(r.range_mm);
         o.distance_valid = 1'b1;
         if (ring_full) begin
            lo = (ring[0] < ring[1]) ? ring[0] : ring[1];
            hi = (ring[0] < ring[1]) ? ring[1] : ring[0];
            c = ring[2];
            o.distance_mm = (c < lo) ? lo : ((c > hi) ? hi : c);
            medians_out++;
         end else begin
            o.distance_mm = r.range_mm;
         end
      end
      o.baseline_eighths = base_set ? base_store : 19'd0;
      o.baseline_valid = base_set;
      return o;
   endfunction

   // stimulus helpers
   function automatic req_type reading(logic [15:0] mm, logic [3:0] status);
      req_type r;
      r.kind = OP_READING;
      r.range_mm = mm;
      r.range_status = status;
      return r;
   endfunction

   function automatic req_type calibrate_cmd();
      req_type r;
      r.kind = OP_CALIBRATE;
      r.range_mm = 16'($urandom);
      r.range_status = 4'($urandom);
      return r;
   endfunction

   // a reading that passes or fails the validity test under the given limit
   function automatic req_type make_reading(logic [15:0] lim, bit good);
      logic [15:0] mm;
      logic [3:0]  status;
      int unsigned pick;
      status = 4'($urandom_range(0, 14));
      if (status >= STATUS_PHASE_FAIL) status = status + 4'd1;
      pick = $urandom_range(0, 9);
      if (good && lim != 16'd0) begin
         if (pick == 0) mm = 16'd1;
         else if (pick == 1) mm = lim;
         else mm = 16'($urandom_range(1, lim));
      end else begin
         mm = 16'($urandom);
         if (pick < 3) begin
            mm = 16'd0;
         end else if (pick < 6 || lim == 16'hFFFF) begin
            status = STATUS_PHASE_FAIL;
         end else begin
            mm = 16'($urandom_range(int'(lim) + 1, 65535));
         end
      end
      return reading(mm, status);
   endfunction

   task automatic add_item(req_type r);
      step_type s;
      s.act = ACT_SEND;
      s.req = r;
      s.value = '0;
      // every third stretch of forty transactions is sent back to back
      s.gap = ((items_built / 40) % 3 == 0) ? 0 : $urandom_range(0, 12);
      items_built++;
      pending_q.push_back(s);
   endtask

   task automatic add_control(act_type a, logic [15:0] v);
      step_type s;
      s.act = a;
      s.req = '0;
      s.value = v;
      s.gap = 0;
      pending_q.push_back(s);
   endtask

   // mostly calibrate sequences and runs of readings, with noise mixed in
   task automatic add_random(int n, logic [15:0] lim);
      int left, k;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 20) begin
            add_item(calibrate_cmd());
            k = $urandom_range(10, 14) + $urandom_range(3, 5);
            for (int i = 0; i < k; i++) begin
               if ($urandom_range(0, 39) == 0) add_item(calibrate_cmd());
               else add_item(make_reading(lim, $urandom_range(0, 6) != 0));
            end
            left -= k + 1;
         end else begin
            k = $urandom_range(3, 15);
            for (int i = 0; i < k; i++)
               add_item(make_reading(lim, $urandom_range(0, 5) != 0));
            left -= k;
         end
      end
   endtask

   // driver: pushes pending transactions, writes max_distance when idle
   always @(posedge clock) begin
      logic        push_n;
      req_type     data_n;
      logic        wen_n;
      logic [15:0] wdata_n;
      push_n = req_push;
      data_n = req_data;
      wen_n = 1'b0;
      wdata_n = csr_write_data;
      if (reset) begin
         push_n = 1'b0;
         gap_left = 0;
         quiet = 0;
      end else begin
         if (req_push && !req_full) begin
            awaited_outputs.push_back(median_calibrate_step(req_data));
            items_sent++;
            push_n = 1'b0;
         end
         if (!req_push && awaited_outputs.size() == 0) quiet++;
         else quiet = 0;
         if (!push_n) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               case (pending_q[0].act)
                  ACT_SEND: begin
                     data_n = pending_q[0].req;
                     push_n = 1'b1;
                     gap_left = pending_q[0].gap;
                     void'(pending_q.pop_front());
                  end
                  ACT_WRITE: begin
                     if (quiet >= SETTLE_CYCLES) begin
                        wen_n = 1'b1;
                        wdata_n = pending_q[0].value;
                        lim_mm = pending_q[0].value;
                        csr_writes++;
                        void'(pending_q.pop_front());
                     end
                  end
                  default: begin
                     if (quiet >= SETTLE_CYCLES) void'(pending_q.pop_front());
                  end
               endcase
            end
         end
      end
      req_push <= push_n;
      req_data <= data_n;
      csr_write_en <= wen_n;
      csr_write_data <= wdata_n;
   end

   // monitor: pops results with random stalls and checks each transaction
   always @(posedge clock) begin
      logic    pop_n;
      rsp_type want;
      pop_n = rsp_pop;
      if (reset) begin
         pop_n = 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            pop_n = 1'b0;
            stall_left = ((results_seen / 45) % 3 == 1) ? 0 : $urandom_range(0, 12);
            results_seen++;
            if (awaited_outputs.size() == 0) begin
               note_fault("result arrived with nothing expected");
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_data.distance_mm !== want.distance_mm
                   || rsp_data.distance_valid !== want.distance_valid
                   || rsp_data.calibrating !== want.calibrating
                   || rsp_data.baseline_eighths !== want.baseline_eighths
                   || rsp_data.baseline_valid !== want.baseline_valid)
                  note_fault($sformatf({"result %0d: expected dist %0d/%0b cal %0b base %0d/%0b,",
                                        " got dist %0d/%0b cal %0b base %0d/%0b"},
                                       results_seen, want.distance_mm, want.distance_valid,
                                       want.calibrating, want.baseline_eighths,
                                       want.baseline_valid, rsp_data.distance_mm,
                                       rsp_data.distance_valid, rsp_data.calibrating,
                                       rsp_data.baseline_eighths, rsp_data.baseline_valid));
            end
         end
         if (!pop_n) begin
            if (stall_left > 0) stall_left--;
            else pop_n = 1'b1;
         end
      end
      rsp_pop <= pop_n;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  awaited_outputs.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus plan, reset and end of run
   initial begin
      // directed: validity edges at the reset limit, warm-up and first median
      add_item(reading(16'd0, 4'd0));
      add_item(reading(16'd800, 4'd0));
      add_item(reading(16'd801, 4'd0));
      add_item(reading(16'd100, STATUS_PHASE_FAIL));
      add_item(reading(16'd100, 4'd15));
      add_item(reading(16'd1, 4'd0));
      // calibrate, restarted part way through collection
      add_item(calibrate_cmd());
      add_item(reading(16'd500, 4'd2));
      add_item(reading(16'd20, 4'd0));
      add_item(calibrate_cmd());
      add_item(reading(16'd300, 4'd0));
      add_item(reading(16'd1, 4'd3));
      add_item(reading(16'd800, 4'd8));
      add_item(reading(16'd0, 4'd0));
      add_item(reading(16'd300, 4'd0));
      add_item(reading(16'd420, 4'd1));
      add_item(reading(16'd800, 4'd0));
      add_item(reading(16'd1, 4'd0));
      add_item(reading(16'd555, 4'd7));
      add_item(reading(16'd299, 4'd0));
      add_item(reading(16'd301, 4'd9));
      // priming, with an invalid reading ignored on the way
      add_item(reading(16'd250, 4'd0));
      add_item(reading(16'd250, STATUS_PHASE_FAIL));
      add_item(reading(16'd700, 4'd0));
      add_item(reading(16'd10, 4'd0));
      add_item(reading(16'd400, 4'd0));

      // random phases across several max_distance settings
      add_control(ACT_WRITE, 16'hFFFF);
      add_random(100, 16'hFFFF);
      add_control(ACT_DRAIN, '0);
      add_random(100, 16'hFFFF);
      add_control(ACT_WRITE, 16'd0);
      add_random(60, 16'd0);
      add_control(ACT_WRITE, 16'd1);
      add_random(50, 16'd1);
      begin
         logic [15:0] mid;
         mid = 16'($urandom_range(2, 65534));
         add_control(ACT_WRITE, mid);
         add_random(100, mid);
         add_control(ACT_DRAIN, '0);
         add_random(100, mid);
      end
      add_control(ACT_WRITE, MAX_DISTANCE_RESET);
      add_random(140, MAX_DISTANCE_RESET);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_push || awaited_outputs.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (awaited_outputs.size() != 0)
         note_fault($sformatf("%0d expected results never arrived", awaited_outputs.size()));

      $display("checked %0d results from %0d transactions under %0d max_distance writes",
               results_seen, items_sent, csr_writes);
      $display("%0d calibrations completed, %0d median outputs, %0d mismatches",
               cal_done, medians_out, fault_count);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
